// File: sv/touch_gesture_classifier_macros.svh
// Assertion macros used by the gesture classifier RTL.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gesture classifier check failed");

// Consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gesture classifier check failed");

`endif

// File: sv/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

    // Raw converter window.
    localparam logic [11:0] X_MIN = 12'd200;
    localparam logic [11:0] X_MAX = 12'd3900;
    localparam logic [11:0] Y_MIN = 12'd300;
    localparam logic [11:0] Y_MAX = 12'd3800;

    // floor(d * 319 / 3700) and floor(d * 239 / 3500) are computed as
    // (d * MUL) >> 24 with MUL rounded up; the error stays below one step
    // of 1/3700 (1/3500) over the whole clamped range, so the result is exact.
    localparam int unsigned SCALE_SHIFT = 24;
    localparam logic [20:0] SCALE_X_MUL =
        21'((64'd319 * (64'd1 << SCALE_SHIFT) + 64'd3699) / 64'd3700);
    localparam logic [20:0] SCALE_Y_MUL =
        21'((64'd239 * (64'd1 << SCALE_SHIFT) + 64'd3499) / 64'd3500);

    // Register reset values.
    localparam logic [8:0]  SWIPE_THRESHOLD_RST = 9'd30;
    localparam logic [15:0] HOLD_LIMIT_MS_RST   = 16'd500;
    localparam logic [8:0]  DRAG_THRESHOLD_RST  = 9'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_SWIPE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_HOLD_LIMIT_MS   = 2'd1;
    localparam logic [1:0] CFG_DRAG_THRESHOLD  = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_TAP   = 3'd1,
        EV_LEFT  = 3'd2,
        EV_RIGHT = 3'd3,
        EV_UP    = 3'd4,
        EV_DOWN  = 3'd5,
        EV_DRAG  = 3'd6
    } event_kind_t;

    typedef struct packed {
        logic [8:0]  swipe_threshold;
        logic [15:0] hold_limit_ms;
        logic [8:0]  drag_threshold;
    } cfg_t;

    typedef struct packed {
        logic        touched;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [31:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic        touched;
        logic [8:0]  sx;
        logic [7:0]  sy;
        logic [31:0] now_ms;
    } scaled_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [8:0]         pos_x;
        logic [7:0]         pos_y;
        logic signed [9:0]  delta_x;
        logic signed [8:0]  delta_y;
    } result_t;

endpackage

// File: sv/touch_gesture_classifier.sv
`timescale 1ns / 1ps
// A result beat passes the input, scaler and result registers to reach m_tvalid.
// Throughput: one poll per cycle while m_tready is high. Each register holds one
// beat, so new polls are taken while a result waits, until all three are full.
// Reset (aresetn low, synchronous): pipeline emptied, contact state cleared,
// thresholds back to 30 pixels (swipe), 500 ms (hold) and 5 pixels (drag).

// Touch gesture classifier.
//
// Each accepted poll produces exactly one result beat. The pipeline has three
// register stages:
//   1. input register: the raw poll as accepted on the slave side,
//   2. scaler register: coordinates clamped and mapped to screen pixels by a
//      single constant multiply,
//   3. result register: the classifier compares the scaled point with the
//      stored contact start and emits NONE, TAP, a swipe direction or DRAG.
// The contact state lives in the classifier and is updated in the same cycle
// as the result register, so consecutive polls see each other's effect with
// no extra wait. Every stage passes a beat on when the next stage is empty or
// being drained, which keeps the full rate as long as m_tready stays high.
//
// Thresholds must be written on the configuration port only while the block is idle; the block does not enforce this.
// An index beyond the last register is ignored.
module touch_gesture_classifier (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    input  logic        s_tuser,   // touched[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pos_x[8:0], pos_y[16:9], delta_x[26:17],
                                   // delta_y[35:27], zero fill [39:36]
    output logic [2:0]  m_tuser    // event_kind[2:0]
);

    tgc_pkg::cfg_t    cfg_reg;

    logic             s1_valid_reg;
    tgc_pkg::poll_t   s1_item_reg;
    tgc_pkg::poll_t   s1_item_next;

    logic             scl_in_ready;
    logic             scl_out_valid;
    tgc_pkg::scaled_t scl_item;
    logic             cls_in_ready;
    tgc_pkg::result_t result;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swipe_threshold <= tgc_pkg::SWIPE_THRESHOLD_RST;
            cfg_reg.hold_limit_ms   <= tgc_pkg::HOLD_LIMIT_MS_RST;
            cfg_reg.drag_threshold  <= tgc_pkg::DRAG_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tgc_pkg::CFG_SWIPE_THRESHOLD: begin
                    cfg_reg.swipe_threshold <= cfg_wdata[8:0];
                end
                tgc_pkg::CFG_HOLD_LIMIT_MS: begin
                    cfg_reg.hold_limit_ms <= cfg_wdata;
                end
                tgc_pkg::CFG_DRAG_THRESHOLD: begin
                    cfg_reg.drag_threshold <= cfg_wdata[8:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: unpack the slave beat into the poll fields.
    always_comb begin
        s1_item_next.touched = s_tuser;
        s1_item_next.raw_x   = s_tdata[11:0];
        s1_item_next.raw_y   = s_tdata[23:12];
        s1_item_next.now_ms  = s_tdata[55:24];
    end

    assign s_tready = !s1_valid_reg || scl_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_item_reg <= s1_item_next;
        end
    end

    tgc_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (scl_in_ready),
        .in_item   (s1_item_reg),
        .out_valid (scl_out_valid),
        .out_ready (cls_in_ready),
        .out_item  (scl_item)
    );

    tgc_classifier u_classifier (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (scl_out_valid),
        .in_ready   (cls_in_ready),
        .in_item    (scl_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Master beat packing.
    assign m_tuser = result.kind;
    assign m_tdata = {4'd0, result.delta_y, result.delta_x, result.pos_y, result.pos_x};

endmodule

// File: sv/tgc_scaler.sv
`timescale 1ns / 1ps

// Clamps the raw readings and maps them onto the 320x240 screen, one poll
// per cycle while out_ready is high, into a registered stage.
module tgc_scaler (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tgc_pkg::poll_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output tgc_pkg::scaled_t out_item
);

    logic             out_valid_reg;
    tgc_pkg::scaled_t item_reg;
    tgc_pkg::scaled_t item_next;

    logic [11:0] clamp_x;
    logic [11:0] clamp_y;
    logic [11:0] off_x;
    logic [11:0] off_y;
    logic [32:0] prod_x;
    logic [31:0] prod_y;

    always_comb begin
        if (in_item.raw_x < tgc_pkg::X_MIN) begin
            clamp_x = tgc_pkg::X_MIN;
        end else if (in_item.raw_x > tgc_pkg::X_MAX) begin
            clamp_x = tgc_pkg::X_MAX;
        end else begin
            clamp_x = in_item.raw_x;
        end
        if (in_item.raw_y < tgc_pkg::Y_MIN) begin
            clamp_y = tgc_pkg::Y_MIN;
        end else if (in_item.raw_y > tgc_pkg::Y_MAX) begin
            clamp_y = tgc_pkg::Y_MAX;
        end else begin
            clamp_y = in_item.raw_y;
        end
        off_x  = clamp_x - tgc_pkg::X_MIN;
        off_y  = clamp_y - tgc_pkg::Y_MIN;
        prod_x = 33'(off_x) * 33'(tgc_pkg::SCALE_X_MUL);
        prod_y = 32'(off_y) * 32'(tgc_pkg::SCALE_Y_MUL);

        item_next.touched = in_item.touched;
        item_next.sx      = prod_x[32:24];
        item_next.sy      = prod_y[31:24];
        item_next.now_ms  = in_item.now_ms;
    end

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: sv/tgc_classifier.sv
`timescale 1ns / 1ps
`include "touch_gesture_classifier_macros.svh"

// Holds the contact state and turns each scaled poll into one result beat.
module tgc_classifier (
    input  logic             aclk,
    input  logic             aresetn,
    input  tgc_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  tgc_pkg::scaled_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output tgc_pkg::result_t out_result
);

    logic             m_valid_reg;
    tgc_pkg::result_t result_reg;
    tgc_pkg::result_t result_next;

    logic        in_contact_reg;
    logic        in_contact_next;
    logic [8:0]  start_x_reg;
    logic [8:0]  start_x_next;
    logic [7:0]  start_y_reg;
    logic [7:0]  start_y_next;
    logic [8:0]  last_x_reg;
    logic [8:0]  last_x_next;
    logic [7:0]  last_y_reg;
    logic [7:0]  last_y_next;
    logic [31:0] start_ms_reg;
    logic [31:0] start_ms_next;

    logic              load;
    logic signed [9:0] dx_cur;
    logic signed [8:0] dy_cur;
    logic [8:0]        ax_cur;
    logic [7:0]        ay_cur;
    logic signed [9:0] dx_rel;
    logic signed [8:0] dy_rel;
    logic [8:0]        ax_rel;
    logic [7:0]        ay_rel;
    logic [31:0]       held_ms;

    assign in_ready   = !m_valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign out_valid  = m_valid_reg;
    assign out_result = result_reg;

    always_comb begin
        dx_cur  = $signed({1'b0, in_item.sx}) - $signed({1'b0, start_x_reg});
        dy_cur  = $signed({1'b0, in_item.sy}) - $signed({1'b0, start_y_reg});
        ax_cur  = 9'(dx_cur[9] ? -dx_cur : dx_cur);
        ay_cur  = 8'(dy_cur[8] ? -dy_cur : dy_cur);
        dx_rel  = $signed({1'b0, last_x_reg}) - $signed({1'b0, start_x_reg});
        dy_rel  = $signed({1'b0, last_y_reg}) - $signed({1'b0, start_y_reg});
        ax_rel  = 9'(dx_rel[9] ? -dx_rel : dx_rel);
        ay_rel  = 8'(dy_rel[8] ? -dy_rel : dy_rel);
        held_ms = in_item.now_ms - start_ms_reg;
    end

    always_comb begin
        result_next     = '0;
        in_contact_next = in_contact_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        start_ms_next   = start_ms_reg;

        if (in_item.touched) begin
            last_x_next = in_item.sx;
            last_y_next = in_item.sy;
            if (!in_contact_reg) begin
                // First touched poll: remember where and when the contact began.
                start_x_next    = in_item.sx;
                start_y_next    = in_item.sy;
                start_ms_next   = in_item.now_ms;
                in_contact_next = 1'b1;
            end else if (ax_cur > cfg.drag_threshold ||
                         {1'b0, ay_cur} > cfg.drag_threshold) begin
                result_next.kind    = tgc_pkg::EV_DRAG;
                result_next.pos_x   = in_item.sx;
                result_next.pos_y   = in_item.sy;
                result_next.delta_x = dx_cur;
                result_next.delta_y = dy_cur;
            end
        end else if (in_contact_reg) begin
            in_contact_next = 1'b0;
            if (held_ms <= {16'd0, cfg.hold_limit_ms}) begin
                if (ax_rel < cfg.swipe_threshold &&
                    {1'b0, ay_rel} < cfg.swipe_threshold) begin
                    result_next.kind = tgc_pkg::EV_TAP;
                end else if (ax_rel > {1'b0, ay_rel}) begin
                    result_next.kind = dx_rel[9] ? tgc_pkg::EV_LEFT : tgc_pkg::EV_RIGHT;
                end else begin
                    result_next.kind = dy_rel[8] ? tgc_pkg::EV_UP : tgc_pkg::EV_DOWN;
                end
                result_next.pos_x   = last_x_reg;
                result_next.pos_y   = last_y_reg;
                result_next.delta_x = dx_rel;
                result_next.delta_y = dy_rel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            in_contact_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                m_valid_reg <= in_valid;
            end
            if (load) begin
                in_contact_reg <= in_contact_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg   <= result_next;
            start_x_reg  <= start_x_next;
            start_y_reg  <= start_y_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            start_ms_reg <= start_ms_next;
        end
    end

    `TGC_ASSERT_SAME(a_none_is_zero, aclk, aresetn,
        m_valid_reg && result_reg.kind == tgc_pkg::EV_NONE,
        result_reg.pos_x == 9'd0 && result_reg.pos_y == 8'd0 &&
        result_reg.delta_x == 10'sd0 && result_reg.delta_y == 9'sd0)
    `TGC_ASSERT_NEXT(a_first_touch_silent, aclk, aresetn,
        load && in_item.touched && !in_contact_reg,
        in_contact_reg && result_reg.kind == tgc_pkg::EV_NONE)
    `TGC_ASSERT_NEXT(a_release_ends_contact, aclk, aresetn,
        load && !in_item.touched, !in_contact_reg)
    `TGC_ASSERT_SAME(a_drag_in_contact, aclk, aresetn,
        m_valid_reg && result_reg.kind == tgc_pkg::EV_DRAG, in_contact_reg)

endmodule
